[src/i128_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i128_pkg
// Shared types and operation codes of the 128-bit integer ALU.
// ----------------------------------------------------------------------------
package i128_pkg;

	localparam logic [2:0] OP_SEXT = 3'd0;
	localparam logic [2:0] OP_NEG  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_MUL  = 3'd4;
	localparam logic [2:0] OP_SHL  = 3'd5;
	localparam logic [2:0] OP_SHR  = 3'd6;
	localparam logic [2:0] OP_SAR  = 3'd7;

	localparam int InBits  = 272;
	localparam int OutBits = 128;

	typedef struct packed {
		logic [7:0]   shift_amount;
		logic [63:0]  b_high;
		logic [63:0]  b_low;
		logic [63:0]  a_high;
		logic [63:0]  a_low;
		logic [2:0]   operation;
	} item_t;

endpackage
`default_nettype wire

[src/i128_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i128_mul
// Three-stage 128x128 low-half multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
module i128_mul (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [127:0] a,
	input  wire logic [127:0] b,
	output logic [127:0]      p
);
	// Stage 1: the ten 32x32 products that reach the low 128 bits.
	logic [63:0]  pp_s1 [0:3][0:3];
	// Stage 2: one partial sum per row (per 32-bit limb of a).
	logic [127:0] row_s2 [0:3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					if (i + j < 4)
						pp_s1[i][j] <= a[32*i +: 32] * b[32*j +: 32];
					else
						pp_s1[i][j] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				row_s2[i] <= (128'(pp_s1[i][0]) << (32*i))
					+ (128'(pp_s1[i][1]) << (32*(i+1)))
					+ (128'(pp_s1[i][2]) << (32*(i+2)))
					+ (128'(pp_s1[i][3]) << (32*(i+3)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			p <= row_s2[0] + row_s2[1] + row_s2[2] + row_s2[3];
	end
endmodule
`default_nettype wire

[src/i128_fast.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i128_fast
// Combinational operations: sign extension, negate, add, subtract, shifts.
// ----------------------------------------------------------------------------
module i128_fast (
	input  wire i128_pkg::item_t it,
	output logic [127:0]         r
);
	import i128_pkg::*;

	logic [127:0] a, b;
	logic [7:0]   sh;
	logic         fill;

	assign a    = {it.a_high, it.a_low};
	assign b    = {it.b_high, it.b_low};
	assign sh   = it.shift_amount;
	assign fill = it.a_high[63];

	always_comb begin
		case (it.operation)
			OP_SEXT: r = {{64{it.a_low[63]}}, it.a_low};
			OP_NEG:  r = ~a + 128'd1;
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_SHL:  r = sh[7] ? '0 : a << sh[6:0];
			OP_SHR:  r = sh[7] ? '0 : a >> sh[6:0];
			OP_SAR:  r = sh[7] ? {128{fill}} : 128'($signed(a) >>> sh[6:0]);
			default: r = '0;
		endcase
	end
endmodule
`default_nettype wire

[src/int128_alu.sv]
`default_nettype none
// An accepted input word passes through stages s1, s2 and s3 to the output register.
// Throughput: one word per cycle; the four-stage pipeline advances whenever
// the output register is empty or being taken, so a stall holds every stage.
// The multiplier sets the depth; other operations are aligned to it.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// int128_alu
// Pipelined 128-bit integer ALU with a stream interface.
// ----------------------------------------------------------------------------
module int128_alu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// operation, a_low, a_high, b_low, b_high, shift_amount (lowest first)
	input  wire logic [271:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_low, result_high (lowest first)
	output logic [127:0]      m_tdata
);
	import i128_pkg::*;

	item_t        it;
	logic         adv;
	logic [127:0] fast_r, mul_p;
	logic         v_s1, v_s2, v_s3;
	logic         ism_s1, ism_s2, ism_s3;
	logic [127:0] f_s1, f_s2, f_s3;

	assign it       = item_t'(s_tdata[266:0]);
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	i128_fast u_fast (.it(it), .r(fast_r));

	i128_mul u_mul (
		.clk(clk), .en(adv),
		.a({it.a_high, it.a_low}), .b({it.b_high, it.b_low}),
		.p(mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; m_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ism_s1 <= it.operation == OP_MUL; f_s1 <= fast_r;
			ism_s2 <= ism_s1; f_s2 <= f_s1;
			ism_s3 <= ism_s2; f_s3 <= f_s2;
			m_tdata <= ism_s3 ? mul_p : f_s3;
		end
	end
endmodule
`default_nettype wire

[src/int128_alu_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// int128_alu_chk
// Port-level checks for the ALU stream interface.
// ----------------------------------------------------------------------------
module int128_alu_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken during output stall");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
		else $error("accepted word did not emerge");
endmodule

bind int128_alu int128_alu_chk u_chk (.*);
`default_nettype wire
